// File: sv/smqs_pkg.sv
package smqs_pkg;

    // Request codes carried in the input tuser field.
    localparam logic [3:0] REQ_TICK       = 4'd0;
    localparam logic [3:0] REQ_MOVE_LIFT  = 4'd1;
    localparam logic [3:0] REQ_MOVE_CLAMP = 4'd2;
    localparam logic [3:0] REQ_LOAD       = 4'd3;
    localparam logic [3:0] REQ_UNLOAD     = 4'd4;
    localparam logic [3:0] REQ_STACK      = 4'd5;
    localparam logic [3:0] REQ_OPEN_WIDE  = 4'd6;
    localparam logic [3:0] REQ_PAUSE      = 4'd7;
    localparam logic [3:0] REQ_UNPAUSE    = 4'd8;
    localparam logic [3:0] REQ_CLEAR      = 4'd9;

    // Command kinds handed from the front end to the back end.
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_ENQ     = 3'd1;
    localparam logic [2:0] KIND_PAUSE   = 3'd2;
    localparam logic [2:0] KIND_UNPAUSE = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;
    localparam logic [2:0] KIND_NOP     = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_UP_POS        = 3'd0;
    localparam logic [2:0] CFG_DOWN_POS      = 3'd1;
    localparam logic [2:0] CFG_OPEN_POS      = 3'd2;
    localparam logic [2:0] CFG_CLOSE_POS     = 3'd3;
    localparam logic [2:0] CFG_MIRROR_OFFSET = 3'd4;

    localparam logic [7:0] UP_POS_RST    = 8'd150;
    localparam logic [7:0] DOWN_POS_RST  = 8'd30;
    localparam logic [7:0] OPEN_POS_RST  = 8'd60;
    localparam logic [7:0] CLOSE_POS_RST = 8'd120;

    localparam logic [10:0] MIRROR_BASE = 11'd300;

    localparam logic AXIS_LIFT  = 1'b0;
    localparam logic AXIS_CLAMP = 1'b1;

    localparam int MAX_MOVES = 4;

    typedef struct packed {
        logic [7:0] up_pos;
        logic [7:0] down_pos;
        logic [7:0] open_pos;
        logic [7:0] close_pos;
        logic [7:0] mirror_offset;
    } cfg_t;

    typedef struct packed {
        logic       axis;
        logic [7:0] target;
    } move_t;

    typedef struct packed {
        logic [2:0]                 kind;
        logic [2:0]                 nmoves;
        move_t [MAX_MOVES-1:0]      moves;
    } cmd_t;

endpackage

// File: sv/smqs_front.sv
module smqs_front
    import smqs_pkg::*;
(
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // target_pos
    input  logic [3:0] s_axis_tuser,   // req_type
    input  cfg_t       cfg,
    input  logic       fifo_full,
    output logic       push,
    output cmd_t       cmd
);

    logic [7:0] close_m1;

    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && !fifo_full;

    // Stacking with the closed position at zero saturates instead of wrapping.
    assign close_m1 = (cfg.close_pos != 8'd0) ? cfg.close_pos - 8'd1 : 8'd0;

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = KIND_NOP;
        unique case (s_axis_tuser)
            REQ_TICK:
            begin
                cmd.kind = KIND_TICK;
            end
            REQ_MOVE_LIFT:
            begin
                cmd.kind     = KIND_ENQ;
                cmd.nmoves   = 3'd1;
                cmd.moves[0] = '{axis: AXIS_LIFT, target: s_axis_tdata};
            end
            REQ_MOVE_CLAMP:
            begin
                cmd.kind     = KIND_ENQ;
                cmd.nmoves   = 3'd1;
                cmd.moves[0] = '{axis: AXIS_CLAMP, target: s_axis_tdata};
            end
            REQ_LOAD:
            begin
                cmd.kind     = KIND_ENQ;
                cmd.nmoves   = 3'd3;
                cmd.moves[0] = '{axis: AXIS_LIFT, target: cfg.down_pos};
                cmd.moves[1] = '{axis: AXIS_CLAMP, target: cfg.close_pos};
                cmd.moves[2] = '{axis: AXIS_LIFT, target: cfg.up_pos};
            end
            REQ_UNLOAD:
            begin
                cmd.kind     = KIND_ENQ;
                cmd.nmoves   = 3'd3;
                cmd.moves[0] = '{axis: AXIS_LIFT, target: cfg.down_pos};
                cmd.moves[1] = '{axis: AXIS_CLAMP, target: cfg.open_pos};
                cmd.moves[2] = '{axis: AXIS_LIFT, target: cfg.up_pos};
            end
            REQ_STACK:
            begin
                cmd.kind     = KIND_ENQ;
                cmd.nmoves   = 3'd4;
                cmd.moves[0] = '{axis: AXIS_LIFT, target: cfg.down_pos};
                cmd.moves[1] = '{axis: AXIS_CLAMP, target: close_m1};
                cmd.moves[2] = '{axis: AXIS_CLAMP, target: cfg.close_pos};
                cmd.moves[3] = '{axis: AXIS_LIFT, target: cfg.up_pos};
            end
            REQ_OPEN_WIDE:
            begin
                cmd.kind     = KIND_ENQ;
                cmd.nmoves   = 3'd2;
                cmd.moves[0] = '{axis: AXIS_LIFT, target: cfg.up_pos};
                cmd.moves[1] = '{axis: AXIS_CLAMP, target: cfg.open_pos};
            end
            REQ_PAUSE:
            begin
                cmd.kind = KIND_PAUSE;
            end
            REQ_UNPAUSE:
            begin
                cmd.kind = KIND_UNPAUSE;
            end
            REQ_CLEAR:
            begin
                cmd.kind = KIND_CLEAR;
            end
            default:
            begin
                cmd.kind = KIND_NOP;
            end
        endcase
    end

endmodule

// File: sv/smqs_cmd_fifo.sv
module smqs_cmd_fifo
    import smqs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/smqs_back.sv
module smqs_back
    import smqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic [7:0]  mirror_offset,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ENQ  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    cmd_t          cmd_reg;
    cmd_t          cmd_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    lift_reg;
    logic [7:0]    lift_next;
    logic [7:0]    clamp_reg;
    logic [7:0]    clamp_next;
    logic          paused_reg;
    logic          paused_next;
    logic          done_reg;
    logic          done_next;
    logic          drop_reg;
    logic          drop_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   out_data_reg;
    logic [31:0]   out_data_next;

    logic [8:0]    mem [QUEUE_DEPTH];
    logic [8:0]    rdata_reg;
    logic          rd_en;
    logic          wr_en;
    logic [8:0]    wr_data;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;

    move_t         mv;
    logic [7:0]    cur_pos;
    logic [7:0]    step_pos;
    logic [7:0]    step_new;
    logic [7:0]    step_tgt;
    logic          last_move;
    logic [10:0]   left_wide;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Tail slot: head plus count, wrapped once since the sum stays below twice the depth.
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH) : tail_sum;
    assign wr_addr   = tail_wrap[AW-1:0];

    assign mv        = cmd_reg.moves[idx_reg];
    assign cur_pos   = (mv.axis == AXIS_CLAMP) ? clamp_reg : lift_reg;
    assign wr_data   = {mv.axis, mv.target};
    assign last_move = ({1'b0, idx_reg} == cmd_reg.nmoves - 3'd1);

    assign step_tgt  = rdata_reg[7:0];
    assign step_pos  = rdata_reg[8] ? clamp_reg : lift_reg;
    assign step_new  = (step_pos < step_tgt) ? step_pos + 8'd1 :
                       (step_pos > step_tgt) ? step_pos - 8'd1 : step_pos;

    assign left_wide = MIRROR_BASE - {3'b000, clamp_reg}
                       + {{3{mirror_offset[7]}}, mirror_offset};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        lift_next      = lift_reg;
        clamp_next     = clamp_reg;
        paused_next    = paused_reg;
        done_next      = done_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd;
                    idx_next  = 2'd0;
                    done_next = 1'b0;
                    drop_next = 1'b0;
                    state_next = S_RES;
                    unique case (cmd.kind)
                        KIND_TICK:
                        begin
                            if (count_reg != '0 && !paused_reg)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        KIND_ENQ:
                        begin
                            state_next = S_ENQ;
                        end
                        KIND_PAUSE:
                        begin
                            paused_next = 1'b1;
                        end
                        KIND_UNPAUSE:
                        begin
                            paused_next = 1'b0;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_RES;
                        end
                    endcase
                end
            end
            S_ENQ:
            begin
                // Moves whose axis already sits at the target are skipped.
                if (mv.target != cur_pos)
                begin
                    if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                if (last_move)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            S_RD:
            begin
                if (rdata_reg[8] == AXIS_CLAMP)
                begin
                    clamp_next = step_new;
                end
                else
                begin
                    lift_next = step_new;
                end
                if (step_new == step_tgt)
                begin
                    head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                end
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, drop_reg, done_reg, (count_reg != '0),
                                      left_wide[9:0], clamp_reg, lift_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            head_reg      <= '0;
            count_reg     <= '0;
            lift_reg      <= UP_POS_RST;
            clamp_reg     <= CLOSE_POS_RST;
            paused_reg    <= 1'b0;
            done_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            lift_reg      <= lift_next;
            clamp_reg     <= clamp_next;
            paused_reg    <= paused_next;
            done_reg      <= done_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

endmodule

// File: sv/servo_move_queue_stepper.sv
// Claw servo move queue. Each input transaction is a request (tick, single move, load, unload,
// stack, open wide, pause, unpause or clear) and yields exactly one output transaction that
// reports the lift and right clamp positions, the mirrored left clamp command, whether moves
// are queued, whether this tick finished the head move, and whether a full queue dropped a
// move. Requests are decoded and buffered in a two-entry command queue, so the input side keeps
// accepting while a result waits, until both entries fill. The executing side handles one
// request at a time: a tick that steps the head move passes a read state, as the head entry
// comes from the move memory's registered read port; a tick with nothing to do, pause,
// unpause, clear and unknown codes go straight to the result state; a request adding moves
// queues them in the enqueue state. Configuration writes do not move the current positions.
module servo_move_queue_stepper
    import smqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // target_pos
    input  logic [3:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lift_pos[7:0], right_clamp_pos[15:8], left_clamp_cmd[25:16], busy_res[26],
    // move_done[27], dropped[28], zero fill[31:29]
    output logic [31:0] m_axis_tdata
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic fifo_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_UP_POS:        cfg_next.up_pos        = cfg_wdata;
                CFG_DOWN_POS:      cfg_next.down_pos      = cfg_wdata;
                CFG_OPEN_POS:      cfg_next.open_pos      = cfg_wdata;
                CFG_CLOSE_POS:     cfg_next.close_pos     = cfg_wdata;
                CFG_MIRROR_OFFSET: cfg_next.mirror_offset = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_pos        <= UP_POS_RST;
            cfg_reg.down_pos      <= DOWN_POS_RST;
            cfg_reg.open_pos      <= OPEN_POS_RST;
            cfg_reg.close_pos     <= CLOSE_POS_RST;
            cfg_reg.mirror_offset <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    smqs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg_reg),
        .fifo_full     (fifo_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    smqs_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    smqs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_pop       (pop),
        .mirror_offset (cfg_reg.mirror_offset),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: verif/servo_move_queue_stepper_tb.sv
module servo_move_queue_stepper_tb
    import smqs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 16;
    localparam int POS_MAX = 180;
    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int SETTLE_CYCLES = 12;
    localparam int PRINT_LIMIT = 40;

    localparam logic [3:0] REQ_FIRST_UNKNOWN = 4'd10;
    localparam logic [3:0] REQ_LAST_UNKNOWN  = 4'd15;
    localparam logic [2:0] CFG_SPARE_FIRST   = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST    = 3'd7;

    // Field order matches the output tdata packing, lowest field last.
    typedef struct packed {
        logic       dropped;
        logic       move_done;
        logic       busy;
        logic [9:0] left_cmd;
        logic [7:0] right_pos;
        logic [7:0] lift_pos;
    } servo_state_t;

    typedef struct {
        logic [3:0]   req;
        logic [7:0]   tgt;
        bit           typed;
        servo_state_t want;
    } request_row_t;

    localparam servo_state_t AT_RESET = '{dropped: 1'b0, move_done: 1'b0, busy: 1'b0,
                                          left_cmd: 10'd180, right_pos: 8'd120,
                                          lift_pos: 8'd150};
    localparam servo_state_t AT_RESET_BUSY = '{dropped: 1'b0, move_done: 1'b0, busy: 1'b1,
                                               left_cmd: 10'd180, right_pos: 8'd120,
                                               lift_pos: 8'd150};

    request_row_t opening_rows [DIRECTED_ROWS] = '{
        '{REQ_TICK,          8'd0,   1'b1, AT_RESET},
        '{REQ_FIRST_UNKNOWN, 8'd0,   1'b1, AT_RESET},
        '{REQ_LAST_UNKNOWN,  8'd255, 1'b1, AT_RESET},
        '{REQ_MOVE_LIFT,     8'd150, 1'b1, AT_RESET},
        '{REQ_MOVE_CLAMP,    8'd120, 1'b1, AT_RESET},
        '{REQ_PAUSE,         8'd0,   1'b1, AT_RESET},
        '{REQ_MOVE_LIFT,     8'd152, 1'b0, '0},
        '{REQ_MOVE_LIFT,     8'd152, 1'b0, '0},
        '{REQ_TICK,          8'd0,   1'b1, AT_RESET_BUSY},
        '{REQ_UNPAUSE,       8'd0,   1'b0, '0},
        '{REQ_UNPAUSE,       8'd0,   1'b0, '0},
        '{REQ_TICK,          8'd0,   1'b0, '0},
        '{REQ_TICK,          8'd0,   1'b0, '0},
        // The second move to 152 is now at the head with nothing left to do.
        '{REQ_TICK,          8'd0,   1'b0, '0},
        '{REQ_MOVE_LIFT,     8'd0,   1'b0, '0},
        '{REQ_MOVE_CLAMP,    8'd180, 1'b0, '0},
        '{REQ_LOAD,          8'd0,   1'b0, '0},
        '{REQ_UNLOAD,        8'd0,   1'b0, '0},
        '{REQ_STACK,         8'd0,   1'b0, '0},
        '{REQ_OPEN_WIDE,     8'd0,   1'b0, '0},
        '{REQ_STACK,         8'd0,   1'b0, '0},
        '{REQ_MOVE_CLAMP,    8'd0,   1'b0, '0},
        '{REQ_OPEN_WIDE,     8'd0,   1'b0, '0},
        '{REQ_CLEAR,         8'd0,   1'b0, '0},
        '{REQ_TICK,          8'd0,   1'b0, '0},
        '{REQ_MOVE_LIFT,     8'd180, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    // Shadow of the claw state.
    cfg_t         claw_cfg;
    move_t        move_ring [RING_DEPTH];
    int           ring_head;
    int           moves_held;
    logic [7:0]   lift_now;
    logic [7:0]   clamp_now;
    bit           paused_now;
    bit           lost_move;

    servo_state_t awaited_states [$];
    int           mismatch_count;
    int           feed_gap_pct;
    int           drain_stall_pct;

    servo_move_queue_stepper #(.QUEUE_DEPTH(RING_DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void queue_move(input logic axis, input logic [7:0] target);
        logic [7:0] cur;
        cur = (axis == AXIS_CLAMP) ? clamp_now : lift_now;
        if (cur == target)
            return;
        if (moves_held >= RING_DEPTH)
        begin
            lost_move = 1'b1;
            return;
        end
        move_ring[(ring_head + moves_held) % RING_DEPTH] = '{axis: axis, target: target};
        moves_held++;
    endfunction

    function automatic servo_state_t apply_request(input logic [3:0] req,
                                                   input logic [7:0] tgt);
        servo_state_t outcome;
        logic [7:0]   close_less;
        move_t        head_move;
        bit           arrived;
        int           left;
        close_less = (claw_cfg.close_pos != 8'd0) ? claw_cfg.close_pos - 8'd1 : 8'd0;
        arrived = 1'b0;
        lost_move = 1'b0;
        case (req)
            REQ_TICK:
            begin
                if (moves_held != 0 && !paused_now)
                begin
                    head_move = move_ring[ring_head];
                    if (head_move.axis == AXIS_CLAMP)
                    begin
                        if (clamp_now < head_move.target)
                            clamp_now++;
                        else if (clamp_now > head_move.target)
                            clamp_now--;
                        arrived = (clamp_now == head_move.target);
                    end
                    else
                    begin
                        if (lift_now < head_move.target)
                            lift_now++;
                        else if (lift_now > head_move.target)
                            lift_now--;
                        arrived = (lift_now == head_move.target);
                    end
                    if (arrived)
                    begin
                        ring_head = (ring_head + 1) % RING_DEPTH;
                        moves_held--;
                    end
                end
            end
            REQ_MOVE_LIFT:  queue_move(AXIS_LIFT, tgt);
            REQ_MOVE_CLAMP: queue_move(AXIS_CLAMP, tgt);
            REQ_LOAD:
            begin
                queue_move(AXIS_LIFT, claw_cfg.down_pos);
                queue_move(AXIS_CLAMP, claw_cfg.close_pos);
                queue_move(AXIS_LIFT, claw_cfg.up_pos);
            end
            REQ_UNLOAD:
            begin
                queue_move(AXIS_LIFT, claw_cfg.down_pos);
                queue_move(AXIS_CLAMP, claw_cfg.open_pos);
                queue_move(AXIS_LIFT, claw_cfg.up_pos);
            end
            REQ_STACK:
            begin
                queue_move(AXIS_LIFT, claw_cfg.down_pos);
                queue_move(AXIS_CLAMP, close_less);
                queue_move(AXIS_CLAMP, claw_cfg.close_pos);
                queue_move(AXIS_LIFT, claw_cfg.up_pos);
            end
            REQ_OPEN_WIDE:
            begin
                queue_move(AXIS_LIFT, claw_cfg.up_pos);
                queue_move(AXIS_CLAMP, claw_cfg.open_pos);
            end
            REQ_PAUSE:   paused_now = 1'b1;
            REQ_UNPAUSE: paused_now = 1'b0;
            // Clearing leaves the head pointer where it is.
            REQ_CLEAR:   moves_held = 0;
            default: ;
        endcase
        left = 300 - int'(clamp_now) + int'($signed(claw_cfg.mirror_offset));
        outcome.lift_pos  = lift_now;
        outcome.right_pos = clamp_now;
        outcome.left_cmd  = left[9:0];
        outcome.busy      = (moves_held != 0);
        outcome.move_done = arrived;
        outcome.dropped   = lost_move;
        return outcome;
    endfunction

    function automatic logic [7:0] near_pos(input logic [7:0] pos, input int lowest);
        int v;
        v = int'(pos) + int'($urandom_range(8)) - 4;
        if (v < lowest)
            v = lowest;
        if (v > POS_MAX)
            v = POS_MAX;
        return v[7:0];
    endfunction

    task automatic issue_request(input logic [3:0] req, input logic [7:0] tgt,
                                 input bit typed, input servo_state_t want);
        servo_state_t predicted;
        while ($urandom_range(99) < feed_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tgt;
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_request(req, tgt);
        awaited_states.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_UP_POS:        claw_cfg.up_pos        = value;
            CFG_DOWN_POS:      claw_cfg.down_pos      = value;
            CFG_OPEN_POS:      claw_cfg.open_pos      = value;
            CFG_CLOSE_POS:     claw_cfg.close_pos     = value;
            CFG_MIRROR_OFFSET: claw_cfg.mirror_offset = value;
            default: ;
        endcase
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_states.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Even phases push the registers to their extremes or to random values; odd phases
    // put the targets a few steps from the current positions so sequences finish quickly.
    task automatic load_settings(input int phase);
        logic [7:0] v_up, v_down, v_open, v_close, v_trim;
        case (phase)
            0:
            begin
                v_up = 8'd180; v_down = 8'd0; v_open = 8'd0; v_close = 8'd180;
                v_trim = 8'h80;
            end
            2:
            begin
                v_up = 8'd0; v_down = 8'd180; v_open = 8'd180; v_close = 8'd1;
                v_trim = 8'h7f;
            end
            4:
            begin
                v_up    = 8'($urandom_range(POS_MAX));
                v_down  = 8'($urandom_range(POS_MAX));
                v_open  = 8'($urandom_range(POS_MAX));
                v_close = 8'($urandom_range(POS_MAX, 1));
                v_trim  = 8'($urandom_range(255));
            end
            default:
            begin
                v_up    = near_pos(lift_now, 0);
                v_down  = near_pos(lift_now, 0);
                v_open  = near_pos(clamp_now, 0);
                v_close = near_pos(clamp_now, 1);
                v_trim  = 8'($urandom_range(255));
            end
        endcase
        write_reg(CFG_UP_POS, v_up);
        write_reg(CFG_DOWN_POS, v_down);
        write_reg(CFG_OPEN_POS, v_open);
        write_reg(CFG_CLOSE_POS, v_close);
        write_reg(CFG_MIRROR_OFFSET, v_trim);
        write_reg(3'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)), 8'($urandom_range(255)));
        cfg_we <= 1'b0;
    endtask

    task automatic check_result(input logic [31:0] word);
        servo_state_t got, want;
        if (awaited_states.size() == 0)
        begin
            report_mismatch("transaction with nothing expected", int'(word), 0);
            return;
        end
        want = awaited_states.pop_front();
        got  = word[28:0];
        if (got.lift_pos !== want.lift_pos)
            report_mismatch("lift_pos", got.lift_pos, want.lift_pos);
        if (got.right_pos !== want.right_pos)
            report_mismatch("right_clamp_pos", got.right_pos, want.right_pos);
        if (got.left_cmd !== want.left_cmd)
            report_mismatch("left_clamp_cmd", $signed(got.left_cmd), $signed(want.left_cmd));
        if (got.busy !== want.busy)
            report_mismatch("busy_res", got.busy, want.busy);
        if (got.move_done !== want.move_done)
            report_mismatch("move_done", got.move_done, want.move_done);
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
        if (word[31:29] !== 3'd0)
            report_mismatch("tdata fill", word[31:29], 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= drain_stall_pct);
    end

    initial
    begin
        logic [3:0] req;
        logic [7:0] tgt;
        int         pick;

        mismatch_count  = 0;
        feed_gap_pct    = 28;
        drain_stall_pct = 76;
        claw_cfg = '{up_pos: UP_POS_RST, down_pos: DOWN_POS_RST, open_pos: OPEN_POS_RST,
                     close_pos: CLOSE_POS_RST, mirror_offset: 8'd0};
        for (int i = 0; i < RING_DEPTH; i++)
            move_ring[i] = '0;
        ring_head  = 0;
        moves_held = 0;
        lift_now   = UP_POS_RST;
        clamp_now  = CLOSE_POS_RST;
        paused_now = 1'b0;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= CFG_UP_POS;
        cfg_wdata     <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= REQ_TICK;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
            issue_request(opening_rows[i].req, opening_rows[i].tgt,
                          opening_rows[i].typed, opening_rows[i].want);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            load_settings(phase);
            case (phase / 2)
                0:
                begin
                    feed_gap_pct = 28; drain_stall_pct = 76;
                end
                1:
                begin
                    feed_gap_pct = 76; drain_stall_pct = 28;
                end
                default:
                begin
                    feed_gap_pct = 0; drain_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                tgt  = 8'($urandom_range(POS_MAX));
                if (pick < 50)
                    req = REQ_TICK;
                else if (pick < 62)
                begin
                    req = REQ_MOVE_LIFT;
                    if ($urandom_range(1))
                        tgt = near_pos(lift_now, 0);
                end
                else if (pick < 74)
                begin
                    req = REQ_MOVE_CLAMP;
                    if ($urandom_range(1))
                        tgt = near_pos(clamp_now, 0);
                end
                else if (pick < 78)
                    req = REQ_LOAD;
                else if (pick < 82)
                    req = REQ_UNLOAD;
                else if (pick < 86)
                    req = REQ_STACK;
                else if (pick < 90)
                    req = REQ_OPEN_WIDE;
                else if (pick < 92)
                    req = REQ_PAUSE;
                else if (pick < 97)
                    req = REQ_UNPAUSE;
                else if (pick < 99)
                    req = REQ_CLEAR;
                else
                    req = 4'($urandom_range(REQ_LAST_UNKNOWN, REQ_FIRST_UNKNOWN));
                issue_request(req, tgt, 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0 && awaited_states.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
